// ===== rtl/core/lie_pkg.sv =====
// Shared constants and types for the line input editor.
`default_nettype none

package lie_pkg;

  localparam int MAX_LINE = 256;

  localparam int PosW = 9;

  localparam logic [PosW-1:0] CAP_LIMIT =
    (MAX_LINE > 511) ? 9'd511 : PosW'(MAX_LINE);

  localparam logic [PosW-1:0] CAP_RESET =
    (9'd256 > CAP_LIMIT) ? CAP_LIMIT : 9'd256;

  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [PosW:0] TERM_LEN = 10'd3;

  typedef enum logic [2:0] {
    EV_STORE    = 3'd0,
    EV_ERASE    = 3'd1,
    EV_LINE_END = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_IGNORED  = 3'd4
  } event_kind_t;

  // One decoded byte: a single result, or a CR/LF/NUL run when multi is set.
  typedef struct packed {
    event_kind_t      kind;
    logic [PosW-1:0]  pos;
    logic [7:0]       value;
    logic             we;
    logic [PosW-1:0]  len;
    logic             multi;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/core/lie_step.sv =====
// Per-byte decode: result descriptor and next line position.
`default_nettype none

module lie_step (
  input  wire logic [7:0]               rx_byte,
  input  wire logic [lie_pkg::PosW-1:0] pos,
  input  wire logic [lie_pkg::PosW-1:0] cap,
  output lie_pkg::run_t                 run,
  output logic [lie_pkg::PosW-1:0]      pos_next
);

  logic                      is_term;
  logic                      is_bs;
  logic [lie_pkg::PosW-1:0]  pos_m1;
  logic [lie_pkg::PosW:0]    term_end;

  assign is_term  = (rx_byte == lie_pkg::CH_LF) || (rx_byte == lie_pkg::CH_CR);
  assign is_bs    = (rx_byte == lie_pkg::CH_DEL) || (rx_byte == lie_pkg::CH_BS);
  assign pos_m1   = pos - 9'd1;
  assign term_end = {1'b0, pos} + lie_pkg::TERM_LEN;

  always_comb begin
    run.kind  = lie_pkg::EV_IGNORED;
    run.pos   = '0;
    run.value = '0;
    run.we    = 1'b0;
    run.len   = '0;
    run.multi = 1'b0;
    pos_next  = pos;
    priority if (is_term) begin
      pos_next = '0;
      if (term_end > {1'b0, cap}) begin
        run.kind = lie_pkg::EV_OVERFLOW;
        run.len  = cap + 9'd1;
      end else begin
        run.kind  = lie_pkg::EV_LINE_END;
        run.pos   = pos;
        run.value = lie_pkg::CH_CR;
        run.we    = 1'b1;
        run.len   = term_end[lie_pkg::PosW-1:0];
        run.multi = 1'b1;
      end
    end else if (is_bs) begin
      if (pos != '0) begin
        pos_next = pos_m1;
        run.kind = lie_pkg::EV_ERASE;
        if (pos_m1 < cap) begin
          run.pos = pos_m1;
          run.we  = 1'b1;
        end
      end
    end else if (pos < cap) begin
      run.kind  = lie_pkg::EV_STORE;
      run.pos   = pos;
      run.value = rx_byte;
      run.we    = 1'b1;
      pos_next  = pos + 9'd1;
    end else begin
      run.kind = lie_pkg::EV_OVERFLOW;
      run.len  = cap + 9'd1;
      pos_next = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/line_input_editor.sv =====
// Line input editor: assembles a text line as a stream of buffer writes.
//
// Input channel: in_valid / in_stall carry one received byte (in_rx_byte) per
// transfer. Result channel: out_valid / out_stall carry one buffer write per
// transfer, with event kind, position, value, enable, line length and a
// last_of_run flag on the final write caused by a byte.
// Config: cfg_write_en loads cfg_write_data as the line capacity, clamped to
// MAX_LINE. Write it only while no byte is in flight.
// Each byte passes through the input register, then the result register.
// Throughput: one byte per cycle while out_stall is low for ordinary bytes,
// backspaces and overflows; a CR or LF that fits produces three results (CR,
// LF, NUL), so the result register holds until the last is taken and the
// input stage waits behind it. An empty input register takes a new byte while a
// result waits on out_stall. Reset: synchronous, active low; line position
// cleared, capacity 256, both stages empty. A stalled result holds all its fields.
`default_nettype none

module line_input_editor (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_event_kind,
  output logic [7:0]                     out_write_position,
  output logic [7:0]                     out_write_value,
  output logic                           out_write_enable,
  output logic [8:0]                     out_line_length,
  output logic                           out_last_of_run,
  input  wire logic                      cfg_write_en,
  input  wire logic [8:0]                cfg_write_data
);

  logic                      in_valid_r;
  logic [7:0]                in_byte_r;
  logic [lie_pkg::PosW-1:0]  pos_r;
  logic [lie_pkg::PosW-1:0]  cap_r;
  logic                      out_valid_r;
  lie_pkg::run_t             run_r;
  logic [1:0]                idx_r;

  lie_pkg::run_t             run_nxt;
  logic [lie_pkg::PosW-1:0]  pos_nxt;
  logic [lie_pkg::PosW-1:0]  cap_nxt;
  logic [lie_pkg::PosW-1:0]  out_pos_full;
  logic                      load_out;
  logic                      in_xfer;

  lie_step u_step (
    .rx_byte  (in_byte_r),
    .pos      (pos_r),
    .cap      (cap_r),
    .run      (run_nxt),
    .pos_next (pos_nxt)
  );

  assign out_last_of_run = !run_r.multi || (idx_r == 2'd2);
  assign load_out        = !out_valid_r || (!out_stall && out_last_of_run);
  assign in_stall        = in_valid_r && !load_out;
  assign in_xfer         = in_valid && !in_stall;
  assign cap_nxt         = (cfg_write_data > lie_pkg::CAP_LIMIT) ? lie_pkg::CAP_LIMIT
                                                                 : cfg_write_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      cap_r       <= lie_pkg::CAP_RESET;
      idx_r       <= '0;
    end else begin
      if (cfg_write_en) begin
        cap_r <= cap_nxt;
      end
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (load_out) begin
        in_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= in_valid_r;
        idx_r       <= '0;
        if (in_valid_r) begin
          pos_r <= pos_nxt;
        end
      end else if (!out_stall) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_rx_byte;
    end
    if (load_out) begin
      run_r <= run_nxt;
    end
  end

  assign out_pos_full = run_r.pos + {7'd0, idx_r};

  always_comb begin
    out_write_value = run_r.value;
    if (run_r.multi) begin
      unique case (idx_r)
        2'd0:    out_write_value = lie_pkg::CH_CR;
        2'd1:    out_write_value = lie_pkg::CH_LF;
        default: out_write_value = lie_pkg::CH_NUL;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = run_r.kind;
  assign out_write_position = out_pos_full[7:0];
  assign out_write_enable   = run_r.we;
  assign out_line_length    = run_r.len;

endmodule

`default_nettype wire

// ===== rtl/core/lie_checker.sv =====
// Port-level checks for the line input editor, bound to the top level.
`default_nettype none

module lie_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [2:0] out_event_kind,
  input  wire logic [7:0] out_write_position,
  input  wire logic [7:0] out_write_value,
  input  wire logic       out_write_enable,
  input  wire logic [8:0] out_line_length,
  input  wire logic       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_write_position) && $stable(out_write_value)
      && $stable(out_write_enable) && $stable(out_line_length)
      && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && (out_event_kind == lie_pkg::EV_LINE_END)
      && (out_write_position == $past(out_write_position) + 8'd1))
    else $error("line-end run broken");

  a_multi_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_event_kind == lie_pkg::EV_LINE_END
      && out_write_enable)
    else $error("non-final result outside line end");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_write_position == 8'd0 && out_write_value == 8'd0)
    else $error("position or value set without write");

  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == lie_pkg::EV_IGNORED |->
      out_last_of_run && out_line_length == 9'd0)
    else $error("ignored byte result malformed");

endmodule

bind line_input_editor lie_checker u_lie_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_event_kind     (out_event_kind),
  .out_write_position (out_write_position),
  .out_write_value    (out_write_value),
  .out_write_enable   (out_write_enable),
  .out_line_length    (out_line_length),
  .out_last_of_run    (out_last_of_run)
);

`default_nettype wire
